### hw/rtl/alts_pkg.sv
// Types and codes shared by the alias table sampler.
// No dependencies; every other file of the block but alts_div refers to it by scoped names.
package alts_pkg;

	typedef enum logic [1:0] {
		MODE_ADD    = 2'd0,
		MODE_REMOVE = 2'd1,
		MODE_BUILD  = 2'd2,
		MODE_SAMPLE = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		STAT_OK        = 3'd0,
		STAT_EMPTY     = 3'd1,
		STAT_FULL      = 3'd2,
		STAT_BAD_INDEX = 3'd3,
		STAT_NOT_BUILT = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		FSM_IDLE,
		FSM_REMOVE,
		FSM_SUM,
		FSM_SCALE_RD,
		FSM_SCALE_MUL,
		FSM_SCALE_GO,
		FSM_SCALE_DIV,
		FSM_SCAN,
		FSM_PAIR,
		FSM_SMP_TAB,
		FSM_SMP_VAL
	} fsm_t;

	typedef struct packed {
		mode_t        mode;
		logic [15:0]  weight;
		logic [31:0]  entry_value;
		logic [7:0]   entry_index;
		logic [7:0]   rand_index;
		logic [15:0]  rand_frac;
	} req_word_t;

	typedef struct packed {
		status_t      status;
		logic [7:0]   sample_index;
		logic [31:0]  sample_value;
		logic [8:0]   entry_count;
	} rsp_word_t;

endpackage

### hw/rtl/alts_ifs.sv
// Valid/ready channel interfaces for the request and response words.
// Depends on alts_pkg for the word types.
interface alts_req_if;
	logic                 valid;
	logic                 ready;
	alts_pkg::req_word_t  data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface alts_rsp_if;
	logic                 valid;
	logic                 ready;
	alts_pkg::rsp_word_t  data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

### hw/rtl/alts_div.sv
// Restoring divider, one quotient bit per cycle, for the weight scaling.
// Standalone; expects num / 2^QW to be below den.
module alts_div #(
	parameter int NW = 41,
	parameter int DW = 25,
	parameter int QW = 25
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          done,
	output logic [QW-1:0] quo
);
	localparam int CNTW = $clog2(QW + 1);

	logic [DW-1:0]   rem_q;
	logic [QW-1:0]   sh_q;
	logic [DW-1:0]   den_q;
	logic [CNTW-1:0] cnt_q;
	logic            busy_q;
	logic            done_q;
	logic [DW:0]     trial;
	logic            fits;

	assign trial = {rem_q, sh_q[QW-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNTW'(QW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNTW'(1);
				if (cnt_q == CNTW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= DW'(num >> QW);
			sh_q  <= num[QW-1:0];
			den_q <= den;
		end else if (busy_q) begin
			// shift the next numerator bit into the remainder, the quotient bit in at the bottom
			rem_q <= fits ? DW'(trial - {1'b0, den_q}) : trial[DW-1:0];
			sh_q  <= {sh_q[QW-2:0], fits};
		end
	end

	assign done = done_q;
	assign quo  = sh_q;
endmodule

### hw/rtl/alias_table_sampler_unit.sv
// Alias method sampler: entry store, table build sequencer and sample path.
// Depends on alts_pkg, alts_ifs and alts_div.
//
// Usage: one request word on req gives exactly one response word on rsp.
// mode selects add, remove, build or sample; the response carries a status,
// the chosen index and value (zero unless a sample succeeds) and the entry
// count after the operation.
// Steps, from acceptance to response valid:
//   add and every rejected request: answered straight from idle
//   sample: table read, then value read at index or alias
//   remove at index k of n entries: shift walk over the entries above k
//   build of n entries: sum the weights, scale each through the serial
//   divider (or set it to one if all weights are zero), then one scan of
//   the probability table per alias pair and a last scan that finds none.
// One request is in work at a time; req.ready is high only while idle and
// the response register is empty or being taken, so a stalled receiver
// holds the response and back-pressures req.
// Reset empties the table and clears the built flag at once; the stores
// themselves are not cleared and need no sweep.
module alias_table_sampler_unit #(
	parameter int TABLE_DEPTH = 256,
	parameter int FRAC_BITS   = 16,
	parameter int VALUE_BITS  = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	alts_req_if.sink   req,
	alts_rsp_if.source rsp
);
	localparam int AW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW   = $clog2(TABLE_DEPTH + 1);
	localparam int PW   = CW + FRAC_BITS;
	localparam int SW   = 16 + CW;
	localparam int NW   = 16 + CW + FRAC_BITS;
	localparam int CMPW = PW + 16;
	localparam logic [PW-1:0] ONE     = PW'(1) << FRAC_BITS;
	localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

	// stores
	logic [15:0]           w_mem [TABLE_DEPTH];
	logic [VALUE_BITS-1:0] v_mem [TABLE_DEPTH];
	logic [PW-1:0]         p_mem [TABLE_DEPTH];
	logic                  h_mem [TABLE_DEPTH];
	logic [AW-1:0]         a_mem [TABLE_DEPTH];

	logic [15:0]           w_rd;
	logic [VALUE_BITS-1:0] v_rd;
	logic [PW-1:0]         p_rd;
	logic                  h_rd;
	logic [AW-1:0]         a_rd;

	logic                  w_we, v_we, p_we, h_we, a_we;
	logic [AW-1:0]         w_waddr, p_waddr, h_waddr;
	logic [15:0]           w_wdata;
	logic [VALUE_BITS-1:0] v_wdata;
	logic [PW-1:0]         p_wdata;
	logic                  h_wdata;
	logic [AW-1:0]         w_raddr, v_raddr, t_raddr;

	alts_pkg::fsm_t        fsm_q, fsm_d;
	logic [CW-1:0]         count_q;
	logic                  built_q;
	logic [CW-1:0]         rd_q;
	logic                  v_s1;
	logic [CW-1:0]         idx_s1;
	logic [SW-1:0]         sum_q;
	logic [SW-1:0]         prod_q;
	logic [AW-1:0]         lo_q, hi_q;
	logic [PW-1:0]         lo_p_q, hi_p_q;
	logic                  got_lo_q, got_hi_q;
	logic [AW-1:0]         smp_idx_q, pick_q;
	logic [15:0]           frac_q;
	logic                  rsp_v_q;
	alts_pkg::rsp_word_t   rsp_q, res_d;
	logic                  res_ld;

	logic                  fire, rd_go, last_c;
	logic                  s_low, s_high, n_lo, n_hi, pair_hit, scan_end, scale_wr;
	logic                  take;
	logic [AW-1:0]         pick_c;
	logic [CMPW-1:0]       frac_al, prob_al;
	logic                  div_start, div_done;
	logic [PW-1:0]         div_quo;

	alts_div #(.NW(NW), .DW(SW), .QW(PW)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (NW'(prod_q) << FRAC_BITS),
		.den    (sum_q),
		.done   (div_done),
		.quo    (div_quo)
	);

	assign req.ready = (fsm_q == alts_pkg::FSM_IDLE) && (!rsp_v_q || rsp.ready);
	assign fire      = req.valid && req.ready;
	assign rsp.valid = rsp_v_q;
	assign rsp.data  = rsp_q;

	assign rd_go  = rd_q < count_q;
	assign last_c = rd_q == count_q - CW'(1);

	// pairing scan: latest low without alias, latest high
	assign s_low    = (p_rd < ONE) && !h_rd;
	assign s_high   = !s_low && (p_rd > ONE);
	assign n_lo     = got_lo_q || (v_s1 && s_low);
	assign n_hi     = got_hi_q || (v_s1 && s_high);
	assign pair_hit = (fsm_q == alts_pkg::FSM_SCAN) && v_s1 && n_lo && n_hi;
	assign scan_end = (fsm_q == alts_pkg::FSM_SCAN) && v_s1 && !(n_lo && n_hi)
		&& (idx_s1 == count_q - CW'(1));
	assign scale_wr = ((fsm_q == alts_pkg::FSM_SCALE_MUL) && (sum_q == '0))
		|| ((fsm_q == alts_pkg::FSM_SCALE_DIV) && div_done);
	assign div_start = (fsm_q == alts_pkg::FSM_SCALE_GO);

	assign frac_al = CMPW'(frac_q) << FRAC_BITS;
	assign prob_al = CMPW'(p_rd) << 16;
	assign take    = h_rd && !(frac_al < prob_al);
	assign pick_c  = take ? a_rd : smp_idx_q;

	always_comb begin
		fsm_d   = fsm_q;
		w_we    = 1'b0;
		v_we    = 1'b0;
		p_we    = 1'b0;
		h_we    = 1'b0;
		a_we    = 1'b0;
		w_waddr = AW'(count_q);
		w_wdata = req.data.weight;
		v_wdata = VALUE_BITS'(req.data.entry_value);
		p_waddr = AW'(rd_q);
		p_wdata = (fsm_q == alts_pkg::FSM_SCALE_DIV) ? div_quo : ONE;
		h_waddr = AW'(rd_q);
		h_wdata = 1'b0;
		w_raddr = AW'(rd_q);
		v_raddr = (fsm_q == alts_pkg::FSM_SMP_TAB) ? pick_c : AW'(rd_q);
		t_raddr = (fsm_q == alts_pkg::FSM_IDLE) ? AW'(req.data.rand_index) : AW'(rd_q);
		res_ld  = 1'b0;
		res_d.status       = alts_pkg::STAT_OK;
		res_d.sample_index = '0;
		res_d.sample_value = '0;
		res_d.entry_count  = 9'(count_q);
		case (fsm_q)
			alts_pkg::FSM_IDLE: begin
				if (fire) begin
					case (req.data.mode)
						alts_pkg::MODE_ADD: begin
							res_ld = 1'b1;
							if (count_q == DEPTH_C) begin
								res_d.status = alts_pkg::STAT_FULL;
							end else begin
								w_we = 1'b1;
								v_we = 1'b1;
								res_d.entry_count = 9'(count_q + CW'(1));
							end
						end
						alts_pkg::MODE_REMOVE: begin
							if (count_q == '0) begin
								res_ld = 1'b1;
								res_d.status = alts_pkg::STAT_EMPTY;
							end else if (32'(req.data.entry_index) >= 32'(count_q)) begin
								res_ld = 1'b1;
								res_d.status = alts_pkg::STAT_BAD_INDEX;
							end else begin
								fsm_d = alts_pkg::FSM_REMOVE;
							end
						end
						alts_pkg::MODE_BUILD: begin
							if (count_q == '0) begin
								res_ld = 1'b1;
								res_d.status = alts_pkg::STAT_EMPTY;
							end else begin
								fsm_d = alts_pkg::FSM_SUM;
							end
						end
						default: begin
							if (count_q == '0) begin
								res_ld = 1'b1;
								res_d.status = alts_pkg::STAT_EMPTY;
							end else if (!built_q) begin
								res_ld = 1'b1;
								res_d.status = alts_pkg::STAT_NOT_BUILT;
							end else if (32'(req.data.rand_index) >= 32'(count_q)) begin
								res_ld = 1'b1;
								res_d.status = alts_pkg::STAT_BAD_INDEX;
							end else begin
								fsm_d = alts_pkg::FSM_SMP_TAB;
							end
						end
					endcase
				end
			end
			alts_pkg::FSM_REMOVE: begin
				// move the word read last cycle down one place
				w_waddr = AW'(idx_s1 - CW'(1));
				w_wdata = w_rd;
				v_wdata = v_rd;
				w_we    = v_s1;
				v_we    = v_s1;
				if (!rd_go && !v_s1) begin
					res_ld = 1'b1;
					res_d.entry_count = 9'(count_q - CW'(1));
					fsm_d = alts_pkg::FSM_IDLE;
				end
			end
			alts_pkg::FSM_SUM: begin
				if (!rd_go && !v_s1) fsm_d = alts_pkg::FSM_SCALE_RD;
			end
			alts_pkg::FSM_SCALE_RD: begin
				fsm_d = alts_pkg::FSM_SCALE_MUL;
			end
			alts_pkg::FSM_SCALE_MUL: begin
				if (sum_q == '0) begin
					p_we = 1'b1;
					h_we = 1'b1;
					fsm_d = last_c ? alts_pkg::FSM_SCAN : alts_pkg::FSM_SCALE_RD;
				end else begin
					fsm_d = alts_pkg::FSM_SCALE_GO;
				end
			end
			alts_pkg::FSM_SCALE_GO: begin
				fsm_d = alts_pkg::FSM_SCALE_DIV;
			end
			alts_pkg::FSM_SCALE_DIV: begin
				if (div_done) begin
					p_we = 1'b1;
					h_we = 1'b1;
					fsm_d = last_c ? alts_pkg::FSM_SCAN : alts_pkg::FSM_SCALE_RD;
				end
			end
			alts_pkg::FSM_SCAN: begin
				if (pair_hit) begin
					fsm_d = alts_pkg::FSM_PAIR;
				end else if (scan_end) begin
					res_ld = 1'b1;
					fsm_d = alts_pkg::FSM_IDLE;
				end
			end
			alts_pkg::FSM_PAIR: begin
				// high gives up the shortfall of low
				p_we    = 1'b1;
				p_waddr = hi_q;
				p_wdata = hi_p_q + lo_p_q - ONE;
				h_we    = 1'b1;
				h_waddr = lo_q;
				h_wdata = 1'b1;
				a_we    = 1'b1;
				fsm_d   = alts_pkg::FSM_SCAN;
			end
			alts_pkg::FSM_SMP_TAB: begin
				fsm_d = alts_pkg::FSM_SMP_VAL;
			end
			alts_pkg::FSM_SMP_VAL: begin
				res_ld = 1'b1;
				res_d.sample_index = 8'(pick_q);
				res_d.sample_value = 32'(v_rd);
				fsm_d = alts_pkg::FSM_IDLE;
			end
			default: fsm_d = alts_pkg::FSM_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (w_we) w_mem[w_waddr] <= w_wdata;
		if (v_we) v_mem[w_waddr] <= v_wdata;
		if (p_we) p_mem[p_waddr] <= p_wdata;
		if (h_we) h_mem[h_waddr] <= h_wdata;
		if (a_we) a_mem[lo_q] <= hi_q;
		w_rd <= w_mem[w_raddr];
		v_rd <= v_mem[v_raddr];
		p_rd <= p_mem[t_raddr];
		h_rd <= h_mem[t_raddr];
		a_rd <= a_mem[t_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsm_q   <= alts_pkg::FSM_IDLE;
			count_q <= '0;
			built_q <= 1'b0;
			rsp_v_q <= 1'b0;
			v_s1    <= 1'b0;
		end else begin
			fsm_q <= fsm_d;
			if (res_ld) rsp_v_q <= 1'b1;
			else if (rsp.ready) rsp_v_q <= 1'b0;
			if (fsm_q == alts_pkg::FSM_REMOVE || fsm_q == alts_pkg::FSM_SUM
				|| (fsm_q == alts_pkg::FSM_SCAN && !pair_hit)) begin
				v_s1 <= rd_go;
			end else begin
				v_s1 <= 1'b0;
			end
			if (fire && req.data.mode == alts_pkg::MODE_ADD && count_q != DEPTH_C) begin
				count_q <= count_q + CW'(1);
				built_q <= 1'b0;
			end
			if (fire && req.data.mode == alts_pkg::MODE_BUILD && count_q == '0) begin
				built_q <= 1'b0;
			end
			if (fsm_q == alts_pkg::FSM_REMOVE && !rd_go && !v_s1) begin
				count_q <= count_q - CW'(1);
				built_q <= 1'b0;
			end
			if (scan_end) built_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= rd_q;
		if (res_ld) rsp_q <= res_d;
		case (fsm_q)
			alts_pkg::FSM_IDLE: begin
				rd_q      <= (req.data.mode == alts_pkg::MODE_BUILD) ? '0
					: CW'(req.data.entry_index) + CW'(1);
				sum_q     <= '0;
				smp_idx_q <= AW'(req.data.rand_index);
				frac_q    <= req.data.rand_frac;
			end
			alts_pkg::FSM_REMOVE: begin
				if (rd_go) rd_q <= rd_q + CW'(1);
			end
			alts_pkg::FSM_SUM: begin
				if (rd_go) rd_q <= rd_q + CW'(1);
				if (v_s1) sum_q <= sum_q + SW'(w_rd);
				if (!rd_go && !v_s1) rd_q <= '0;
			end
			alts_pkg::FSM_SCALE_MUL: begin
				prod_q <= SW'(w_rd) * SW'(count_q);
			end
			alts_pkg::FSM_SCAN: begin
				if (rd_go) rd_q <= rd_q + CW'(1);
				if (v_s1) begin
					if (s_low) begin
						got_lo_q <= 1'b1;
						lo_q     <= AW'(idx_s1);
						lo_p_q   <= p_rd;
					end else if (s_high) begin
						got_hi_q <= 1'b1;
						hi_q     <= AW'(idx_s1);
						hi_p_q   <= p_rd;
					end
				end
			end
			alts_pkg::FSM_PAIR: begin
				rd_q     <= '0;
				got_lo_q <= 1'b0;
				got_hi_q <= 1'b0;
			end
			alts_pkg::FSM_SMP_TAB: begin
				pick_q <= pick_c;
			end
			default: ;
		endcase
		// advance the scale walk; restart the scan after the last entry
		if (scale_wr) begin
			rd_q <= last_c ? '0 : rd_q + CW'(1);
			if (last_c) begin
				got_lo_q <= 1'b0;
				got_hi_q <= 1'b0;
			end
		end
	end
endmodule

### hw/rtl/alts_checker.sv
// Port-level assertions for alias_table_sampler_unit and the bind that attaches them.
// Depends on alts_pkg for the response word.
module alts_checker #(
	parameter int TABLE_DEPTH = 256
) (
	input logic                clk,
	input logic                arst_n,
	input logic                req_valid,
	input logic                req_ready,
	input logic                rsp_valid,
	input logic                rsp_ready,
	input alts_pkg::rsp_word_t rsp_data
);
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("response word changed while stalled");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |-> !rsp_valid || rsp_ready)
		else $error("request taken while response word blocked");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.status != alts_pkg::STAT_OK
		|-> rsp_data.sample_index == '0 && rsp_data.sample_value == '0)
		else $error("failed operation carries a sample");

	a_count_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_data.status != alts_pkg::STAT_FULL
			|| rsp_data.entry_count == 9'(TABLE_DEPTH))
		&& (rsp_data.status != alts_pkg::STAT_EMPTY || rsp_data.entry_count == '0))
		else $error("status disagrees with entry count");
endmodule

bind alias_table_sampler_unit alts_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_alts_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_data  (rsp.data)
);

### dv/tb_top.sv
// Testbench for the alias table sampler: directed and random add, remove, build and sample words.
// The scoreboard predicts each response word and checks it. Depends on alts_pkg, alts_ifs
// and alias_table_sampler_unit.
module tb_top;

	localparam int DEPTH     = 256;
	localparam longint ONE   = 64'd1 << 16;
	localparam int LIMIT     = 3000000;
	localparam int RAND_WORDS = 270;

	class sampler_scoreboard;
		logic [15:0] weights [DEPTH];
		logic [31:0] values [DEPTH];
		longint      prob [DEPTH];
		logic [7:0]  alias_idx [DEPTH];
		bit          aliased [DEPTH];
		int          count;
		bit          built;
		alts_pkg::rsp_word_t expected [$];
		int          errors;

		function void clear();
			for (int i = 0; i < DEPTH; i++) begin
				weights[i] = '0;
				values[i] = '0;
				prob[i] = 0;
				alias_idx[i] = '0;
				aliased[i] = 0;
			end
			count = 0;
			built = 0;
			errors = 0;
		endfunction

		function void build_tables();
			longint sum;
			int lo, hi;
			bit got_lo, got_hi;
			sum = 0;
			for (int i = 0; i < count; i++)
				sum += weights[i];
			for (int i = 0; i < count; i++) begin
				prob[i] = (sum == 0) ? ONE : (longint'(weights[i]) * count * ONE) / sum;
				aliased[i] = 0;
			end
			for (int p = 0; p <= count; p++) begin
				got_lo = 0;
				got_hi = 0;
				lo = 0;
				hi = 0;
				for (int i = 0; i < count; i++) begin
					if (prob[i] < ONE && !aliased[i]) begin
						got_lo = 1;
						lo = i;
					end else if (prob[i] > ONE) begin
						got_hi = 1;
						hi = i;
					end
					if (got_lo && got_hi)
						break;
				end
				if (!(got_lo && got_hi))
					break;
				aliased[lo] = 1;
				alias_idx[lo] = hi[7:0];
				prob[hi] -= ONE - prob[lo];
			end
			built = 1;
		endfunction

		function void note(alts_pkg::req_word_t w);
			alts_pkg::rsp_word_t r;
			int pick;
			r = '0;
			r.status = alts_pkg::STAT_OK;
			case (w.mode)
				alts_pkg::MODE_ADD: begin
					if (count >= DEPTH) begin
						r.status = alts_pkg::STAT_FULL;
					end else begin
						weights[count] = w.weight;
						values[count] = w.entry_value;
						count++;
						built = 0;
					end
				end
				alts_pkg::MODE_REMOVE: begin
					if (count == 0) begin
						r.status = alts_pkg::STAT_EMPTY;
					end else if (w.entry_index >= count) begin
						r.status = alts_pkg::STAT_BAD_INDEX;
					end else begin
						for (int i = w.entry_index; i + 1 < count; i++) begin
							weights[i] = weights[i + 1];
							values[i] = values[i + 1];
						end
						count--;
						built = 0;
					end
				end
				alts_pkg::MODE_BUILD: begin
					if (count == 0) begin
						r.status = alts_pkg::STAT_EMPTY;
						built = 0;
					end else begin
						build_tables();
					end
				end
				default: begin
					if (count == 0) begin
						r.status = alts_pkg::STAT_EMPTY;
					end else if (!built) begin
						r.status = alts_pkg::STAT_NOT_BUILT;
					end else if (w.rand_index >= count) begin
						r.status = alts_pkg::STAT_BAD_INDEX;
					end else begin
						pick = w.rand_index;
						if (aliased[pick] && !(longint'(w.rand_frac) < prob[pick]))
							pick = alias_idx[pick];
						r.sample_index = pick[7:0];
						r.sample_value = values[pick];
					end
				end
			endcase
			r.entry_count = count[8:0];
			expected = {expected, r};
		endfunction

		function void check(alts_pkg::rsp_word_t got);
			alts_pkg::rsp_word_t exp_w;
			if (expected.size() == 0) begin
				$display("%0t: response word with none expected: %p", $time, got);
				errors++;
				return;
			end
			exp_w = expected.pop_front();
			if (got.status !== exp_w.status) begin
				$display("%0t: status expected %0d actual %0d", $time, exp_w.status,
					got.status);
				errors++;
			end
			if (got.sample_index !== exp_w.sample_index) begin
				$display("%0t: sample_index expected %0d actual %0d", $time,
					exp_w.sample_index, got.sample_index);
				errors++;
			end
			if (got.sample_value !== exp_w.sample_value) begin
				$display("%0t: sample_value expected %h actual %h", $time,
					exp_w.sample_value, got.sample_value);
				errors++;
			end
			if (got.entry_count !== exp_w.entry_count) begin
				$display("%0t: entry_count expected %0d actual %0d", $time,
					exp_w.entry_count, got.entry_count);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	alts_req_if req ();
	alts_rsp_if rsp ();
	sampler_scoreboard sb;
	int burst_left;
	int cycles;
	bit hold_off;

	alias_table_sampler_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req(req.sink),
		.rsp(rsp.source)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Sender: bursts of words, mostly with idle gaps between them.
	task automatic send(alts_pkg::req_word_t w);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				@(negedge clk);
				req.valid = 1'b0;
				req.data = alts_pkg::req_word_t'($urandom);
				repeat (gap - 1) @(negedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		@(negedge clk);
		req.valid = 1'b1;
		req.data = w;
		do @(posedge clk); while (!req.ready);
		sb.note(w);
		burst_left--;
	endtask

	function automatic logic [15:0] pick_weight();
		case ($urandom_range(0, 5))
			0: return 16'd0;
			1: return 16'hffff;
			2: return 16'($urandom_range(1, 8));
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic alts_pkg::req_word_t make(alts_pkg::mode_t m);
		alts_pkg::req_word_t w;
		w = alts_pkg::req_word_t'({$urandom, $urandom, $urandom});
		w.mode = m;
		return w;
	endfunction

	task automatic add(logic [15:0] wt, logic [31:0] v);
		alts_pkg::req_word_t w;
		w = make(alts_pkg::MODE_ADD);
		w.weight = wt;
		w.entry_value = v;
		send(w);
	endtask

	task automatic remove(logic [7:0] idx);
		alts_pkg::req_word_t w;
		w = make(alts_pkg::MODE_REMOVE);
		w.entry_index = idx;
		send(w);
	endtask

	task automatic sample(logic [7:0] idx, logic [15:0] frac);
		alts_pkg::req_word_t w;
		w = make(alts_pkg::MODE_SAMPLE);
		w.rand_index = idx;
		w.rand_frac = frac;
		send(w);
	endtask

	task automatic sample_in_range();
		if (sb.count > 0 && $urandom_range(0, 7) != 0)
			sample(8'($urandom_range(0, sb.count - 1)), 16'($urandom));
		else
			sample(8'($urandom), 16'($urandom));
	endtask

	// Receiver: stall pattern moves through three phases; a long hold-off fills the block.
	always @(negedge clk) begin
		int phase;
		phase = (cycles / 64) % 3;
		if (!arst_n || hold_off)
			rsp.ready = 1'b0;
		else if (phase == 0)
			rsp.ready = 1'b1;
		else if (phase == 1)
			rsp.ready = ($urandom_range(0, 3) != 0);
		else
			rsp.ready = ($urandom_range(0, 3) == 0);
	end

	always @(posedge clk) begin
		if (arst_n && rsp.valid && rsp.ready)
			sb.check(rsp.data);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		int n;
		sb = new();
		sb.clear();
		cycles = 0;
		hold_off = 0;
		burst_left = 0;
		req.valid = 1'b0;
		req.data = '0;
		rsp.ready = 1'b0;
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: empty table, not built, bad indexes, extremes, all-zero weights.
		sample(8'd0, 16'd0);
		remove(8'd0);
		send(make(alts_pkg::MODE_BUILD));
		add(16'd0, 32'h0000_0000);
		add(16'hffff, 32'hffff_ffff);
		add(16'd1, 32'ha5a5_5a5a);
		sample(8'd0, 16'd0);
		send(make(alts_pkg::MODE_BUILD));
		sample(8'd0, 16'd0);
		sample(8'd0, 16'hffff);
		sample(8'd2, 16'hffff);
		sample(8'd3, 16'd0);
		sample(8'hff, 16'h8000);
		remove(8'd3);
		remove(8'hff);
		remove(8'd1);
		sample(8'd0, 16'd0);
		remove(8'd0);
		remove(8'd0);
		add(16'd0, 32'h1234_5678);
		add(16'd0, 32'h8765_4321);
		send(make(alts_pkg::MODE_BUILD));
		sample(8'd1, 16'hffff);
		remove(8'd0);
		remove(8'd0);
		send(make(alts_pkg::MODE_BUILD));

		// Hold the receiver off while words keep coming.
		fork
			begin
				hold_off = 1;
				repeat (400) @(posedge clk);
				hold_off = 0;
			end
		join_none

		n = 0;
		while (n < RAND_WORDS) begin
			if ($urandom_range(0, 9) < 7) begin
				if (sb.count > 20)
					repeat ($urandom_range(4, 12)) begin
						remove(8'($urandom_range(0, sb.count - 1)));
						n++;
					end
				repeat ($urandom_range(1, 6)) begin
					add(pick_weight(), $urandom);
					n++;
				end
				send(make(alts_pkg::MODE_BUILD));
				n++;
				repeat ($urandom_range(2, 10)) begin
					sample_in_range();
					n++;
				end
			end else begin
				case ($urandom_range(0, 3))
					0: add(16'($urandom), $urandom);
					1: remove(sb.count > 0 && $urandom_range(0, 1) ?
						8'($urandom_range(0, sb.count - 1)) : 8'($urandom));
					2: send(make(alts_pkg::MODE_BUILD));
					default: sample_in_range();
				endcase
				n++;
			end
		end

		// Fill the table, overflow it, then build and sample the full table and remove from both ends.
		while (sb.count < DEPTH)
			add(16'($urandom_range(0, 300)), $urandom);
		add(16'hffff, 32'hdead_beef);
		send(make(alts_pkg::MODE_BUILD));
		repeat (12) sample_in_range();
		sample(8'hff, 16'hffff);
		remove(8'd255);
		remove(8'd0);

		@(negedge clk);
		req.valid = 1'b0;
		while (sb.expected.size() != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
		if (sb.errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule
